// File: rtl/calclk_pkg.sv
// Shared types and constants for the configurable calendar clock.
`default_nettype none

package calclk_pkg;

  localparam int TICK_W    = 31;
  localparam int CFG_W     = 16;
  localparam int DAY_W     = 32;
  localparam int MINUTE_W  = 6;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int PROD_W    = CFG_W + MINUTE_W;
  localparam int STEP_W    = $clog2(TICK_W);

  localparam logic [TICK_W-1:0] MAX_TICK = {TICK_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_LOAD    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_DAY_LEN         = 2'd0,
    REG_HOUR_LEN        = 2'd1,
    REG_DAYS_IN_YEAR    = 2'd2,
    REG_DAYS_IN_QUADRUM = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_YEAR,
    S_QUAD,
    S_HOUR,
    S_MIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] quotient;
    logic [CFG_W-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/calclk_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module calclk_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire calclk_pkg::div_req_t req,
  output calclk_pkg::div_rsp_t      rsp
);
  import calclk_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [TICK_W-1:0] dvd;
  logic [CFG_W-1:0]  rem;
  logic [CFG_W-1:0]  dsr;

  logic [CFG_W:0]    rem_sh;
  logic [CFG_W+1:0]  diff;
  logic              q_bit;

  assign rem_sh = {rem, dvd[TICK_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};
  assign q_bit  = ~diff[CFG_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[TICK_W-2:0], q_bit};
      rem <= q_bit ? diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dvd;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// File: rtl/configurable_calendar_clock.sv
// Top level of the configurable calendar clock with its register port.
//
// Channel   Direction  Handshake              Word
// cfg       in         psel/penable/pready    one 16-bit calendar register
// in        in         in_valid/in_ready      opcode, load_value
// out       out        out_valid/out_ready    tick count and calendar fields
//
// Each word runs five divisions in turn on one bit-serial divider; no new word
// is taken until the result is loaded into the output register, and the next
// word can be accepted in the cycle in which that result is offered.
// Reset clears the tick counter, the calendar registers and all handshakes.
// A result that is not taken holds in the output register; the next word is
// still accepted, and the following result waits until the register frees.
`default_nettype none

module configurable_calendar_clock (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [calclk_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [calclk_pkg::PDATA_W-1:0]    pwdata,
  output logic      [calclk_pkg::PDATA_W-1:0]    prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        opcode,
  input  wire logic [calclk_pkg::TICK_W-1:0]     load_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [calclk_pkg::TICK_W-1:0]     tick_count,
  output logic      [calclk_pkg::DAY_W-1:0]      day_number,
  output logic      [calclk_pkg::DAY_W-1:0]      year_number,
  output logic      [calclk_pkg::CFG_W-1:0]      quadrum_number,
  output logic      [calclk_pkg::CFG_W-1:0]      hour_of_day,
  output logic      [calclk_pkg::MINUTE_W-1:0]   minute_of_hour
);
  import calclk_pkg::*;

  logic [CFG_W-1:0]    day_len;
  logic [CFG_W-1:0]    hour_len;
  logic [CFG_W-1:0]    days_in_year;
  logic [CFG_W-1:0]    days_in_quadrum;

  logic [CFG_W-1:0]    d_div;
  logic [CFG_W-1:0]    h_div;
  logic [CFG_W-1:0]    y_div;
  logic [CFG_W-1:0]    q_div;

  state_t              state;
  state_t              state_next;
  logic [TICK_W-1:0]   counter;
  logic [TICK_W-1:0]   counter_next;
  logic [TICK_W-1:0]   days;
  logic [TICK_W-1:0]   years;
  logic [CFG_W-1:0]    rem_day;
  logic [CFG_W-1:0]    quad;
  logic [CFG_W-1:0]    hour;
  logic [MINUTE_W-1:0] minute;
  logic [PROD_W-1:0]   min_prod;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                accept;
  logic                out_load;
  logic                cfg_write;

  calclk_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_len         <= '0;
      hour_len        <= '0;
      days_in_year    <= '0;
      days_in_quadrum <= '0;
    end else if (cfg_write) begin
      case (paddr[PADDR_W-1:2])
        REG_DAY_LEN:         day_len         <= pwdata[CFG_W-1:0];
        REG_HOUR_LEN:        hour_len        <= pwdata[CFG_W-1:0];
        REG_DAYS_IN_YEAR:    days_in_year    <= pwdata[CFG_W-1:0];
        REG_DAYS_IN_QUADRUM: days_in_quadrum <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_DAY_LEN:         prdata = PDATA_W'(day_len);
      REG_HOUR_LEN:        prdata = PDATA_W'(hour_len);
      REG_DAYS_IN_YEAR:    prdata = PDATA_W'(days_in_year);
      REG_DAYS_IN_QUADRUM: prdata = PDATA_W'(days_in_quadrum);
      default:             prdata = '0;
    endcase
  end

  assign d_div = (day_len         == '0) ? CFG_W'(1) : day_len;
  assign h_div = (hour_len        == '0) ? CFG_W'(1) : hour_len;
  assign y_div = (days_in_year    == '0) ? CFG_W'(1) : days_in_year;
  assign q_div = (days_in_quadrum == '0) ? CFG_W'(1) : days_in_quadrum;

  always_comb begin
    case (opcode)
      OP_ADVANCE: counter_next = (counter == MAX_TICK) ? counter : counter + 1'b1;
      OP_CLEAR:   counter_next = '0;
      OP_LOAD:    counter_next = load_value;
      default:    counter_next = counter;
    endcase
  end

  // The remainder times sixty, formed as 64x - 4x.
  assign min_prod = {div_rsp.remainder, 6'b000000}
                  - {{(PROD_W-CFG_W-2){1'b0}}, div_rsp.remainder, 2'b00};

  assign in_ready = (state == S_IDLE) & ~rst;
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = d_div;
    out_load         = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next       = S_DAY;
          div_req.start    = 1'b1;
          div_req.dividend = counter_next;
          div_req.divisor  = d_div;
        end
      end
      S_DAY: begin
        if (div_rsp.done) begin
          state_next       = S_YEAR;
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = y_div;
        end
      end
      S_YEAR: begin
        if (div_rsp.done) begin
          state_next       = S_QUAD;
          div_req.start    = 1'b1;
          div_req.dividend = TICK_W'(div_rsp.remainder);
          div_req.divisor  = q_div;
        end
      end
      S_QUAD: begin
        if (div_rsp.done) begin
          state_next       = S_HOUR;
          div_req.start    = 1'b1;
          div_req.dividend = TICK_W'(rem_day);
          div_req.divisor  = h_div;
        end
      end
      S_HOUR: begin
        if (div_rsp.done) begin
          state_next       = S_MIN;
          div_req.start    = 1'b1;
          div_req.dividend = TICK_W'(min_prod);
          div_req.divisor  = h_div;
        end
      end
      S_MIN: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        counter <= counter_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_rsp.done) begin
      case (state)
        S_DAY: begin
          days    <= div_rsp.quotient;
          rem_day <= div_rsp.remainder;
        end
        S_YEAR:  years  <= div_rsp.quotient;
        S_QUAD:  quad   <= div_rsp.quotient[CFG_W-1:0];
        S_HOUR:  hour   <= div_rsp.quotient[CFG_W-1:0];
        S_MIN:   minute <= div_rsp.quotient[MINUTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tick_count     <= counter;
      day_number     <= DAY_W'(days) + 1'b1;
      year_number    <= DAY_W'(years) + 1'b1;
      quadrum_number <= quad + 1'b1;
      hour_of_day    <= hour;
      minute_of_hour <= minute;
    end
  end

endmodule

`default_nettype wire

// File: rtl/calclk_chk.sv
// Port-level checks for the configurable calendar clock and their binding.
`default_nettype none

module calclk_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [calclk_pkg::TICK_W-1:0]   tick_count,
  input wire logic [calclk_pkg::DAY_W-1:0]    day_number,
  input wire logic [calclk_pkg::DAY_W-1:0]    year_number,
  input wire logic [calclk_pkg::CFG_W-1:0]    quadrum_number,
  input wire logic [calclk_pkg::MINUTE_W-1:0] minute_of_hour
);
  import calclk_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block accepted a word while still working on the previous one");

  a_one_based: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> day_number != '0 && year_number != '0 && quadrum_number != '0)
    else $error("one-based calendar field reads zero");

  a_minute_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> minute_of_hour < MINUTE_W'(60))
    else $error("minute of hour out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tick_count) && $stable(day_number))
    else $error("stalled result word changed");

endmodule

bind configurable_calendar_clock calclk_chk u_calclk_chk (.*);

`default_nettype wire

// File: tb/sv/tb_configurable_calendar_clock.sv
// Self-checking testbench for the configurable calendar clock: commands, calendar math, stalls.
`timescale 1ns / 100ps

module tb_configurable_calendar_clock;
  import calclk_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int LONG_HOLD    = 900;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 1650;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [TICK_W-1:0]   ticks;
    logic [DAY_W-1:0]    day;
    logic [DAY_W-1:0]    year;
    logic [CFG_W-1:0]    quadrum;
    logic [CFG_W-1:0]    hour;
    logic [MINUTE_W-1:0] minute;
  } calendar_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          opcode;
  logic [TICK_W-1:0]   load_value;
  logic                out_valid;
  logic                out_ready;
  logic [TICK_W-1:0]   tick_count;
  logic [DAY_W-1:0]    day_number;
  logic [DAY_W-1:0]    year_number;
  logic [CFG_W-1:0]    quadrum_number;
  logic [CFG_W-1:0]    hour_of_day;
  logic [MINUTE_W-1:0] minute_of_hour;

  logic [TICK_W-1:0] tick_now;
  logic [CFG_W-1:0]  cal_reg [4];
  calendar_t         due_dates [$];
  calendar_t         got;
  calendar_t         want;
  int                error_count;
  int                cycle_count;
  int                stall_left;
  bit                tx_idle_on;
  bit                rx_idle_on;
  bit                hold_request;

  configurable_calendar_clock DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tick_count(tick_count),
    .day_number(day_number),
    .year_number(year_number),
    .quadrum_number(quadrum_number),
    .hour_of_day(hour_of_day),
    .minute_of_hour(minute_of_hour)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_configurable_calendar_clock: errors");
      $finish;
    end
  end

  function automatic logic [31:0] divisor_of(logic [CFG_W-1:0] v);
    return (v == '0) ? 32'd1 : {16'd0, v};
  endfunction

  function automatic calendar_t calendar_of(logic [TICK_W-1:0] t);
    logic [31:0] d;
    logic [31:0] h;
    logic [31:0] y;
    logic [31:0] q;
    logic [31:0] days;
    logic [31:0] rem_day;
    logic [31:0] quad;
    logic [31:0] hour;
    logic [63:0] scaled;
    calendar_t   c;
    d = divisor_of(cal_reg[REG_DAY_LEN]);
    h = divisor_of(cal_reg[REG_HOUR_LEN]);
    y = divisor_of(cal_reg[REG_DAYS_IN_YEAR]);
    q = divisor_of(cal_reg[REG_DAYS_IN_QUADRUM]);
    days    = {1'b0, t} / d;
    rem_day = {1'b0, t} % d;
    quad    = (days % y) / q + 32'd1;
    hour    = rem_day / h;
    scaled  = ({32'd0, rem_day % h} * 64'd60) / {32'd0, h};
    c.ticks   = t;
    c.day     = days + 32'd1;
    c.year    = days / y + 32'd1;
    c.quadrum = quad[CFG_W-1:0];
    c.hour    = hour[CFG_W-1:0];
    c.minute  = scaled[MINUTE_W-1:0];
    return c;
  endfunction

  task automatic track_command(logic [1:0] op, logic [TICK_W-1:0] ld);
    case (op)
      OP_ADVANCE: begin
        if (tick_now != MAX_TICK) tick_now = tick_now + 1'b1;
      end
      OP_CLEAR: tick_now = '0;
      OP_LOAD:  tick_now = ld;
      default: ;
    endcase
    due_dates.push_back(calendar_of(tick_now));
  endtask

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 220);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] expected, logic [63:0] actual);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, what, expected, actual);
  endtask

  task automatic send_word(logic [1:0] op, logic [TICK_W-1:0] ld);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    load_value <= ld;
    do @(posedge clk); while (!in_ready);
    track_command(op, ld);
  endtask

  // Setup phase, access phase, then an idle phase so psel is never re-raised in the same step.
  task automatic apb_cycle(bit wr, reg_idx_t idx, logic [PDATA_W-1:0] wdata,
                           output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_dates.size() != 0) @(posedge clk);
  endtask

  task automatic set_calendar(logic [CFG_W-1:0] d, logic [CFG_W-1:0] h,
                              logic [CFG_W-1:0] y, logic [CFG_W-1:0] q);
    logic [CFG_W-1:0]   vals [4];
    logic [PDATA_W-1:0] rd;
    reg_idx_t           idx;
    vals = '{d, h, y, q};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx = reg_idx_t'(i);
      apb_cycle(1'b1, idx, {16'd0, vals[i]}, rd);
      cal_reg[idx] = vals[i];
    end
    for (int i = 0; i < 4; i++) begin
      idx = reg_idx_t'(i);
      apb_cycle(1'b0, idx, '0, rd);
      if (rd !== {16'd0, cal_reg[idx]})
        report_mismatch($sformatf("register %s readback", idx.name()), 64'(cal_reg[idx]),
                        64'(rd));
    end
  endtask

  function automatic logic [CFG_W-1:0] random_cal_value();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return '0;
      1: return 16'd1;
      2: return '1;
      3, 4, 5: return CFG_W'($urandom_range(2, 30));
      6, 7: return CFG_W'($urandom_range(31, 1500));
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] near_boundary();
    logic [63:0] d;
    logic [63:0] unit;
    logic [63:0] val;
    d = 64'(divisor_of(cal_reg[REG_DAY_LEN]));
    case ($urandom_range(0, 2))
      0: unit = d;
      1: unit = d * 64'(divisor_of(cal_reg[REG_DAYS_IN_QUADRUM]));
      default: unit = d * 64'(divisor_of(cal_reg[REG_DAYS_IN_YEAR]));
    endcase
    val = unit * 64'($urandom_range(1, 40)) + 64'($urandom_range(0, 4)) - 64'd2;
    return val[TICK_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0 && hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(1'b1);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {tick_count, day_number, year_number, quadrum_number, hour_of_day, minute_of_hour};
      if (due_dates.size() == 0) begin
        report_mismatch("word with none pending: tick_count", '0, 64'(got.ticks));
      end else begin
        want = due_dates.pop_front();
        if (got.ticks !== want.ticks)
          report_mismatch("tick_count", 64'(want.ticks), 64'(got.ticks));
        if (got.day !== want.day)
          report_mismatch("day_number", 64'(want.day), 64'(got.day));
        if (got.year !== want.year)
          report_mismatch("year_number", 64'(want.year), 64'(got.year));
        if (got.quadrum !== want.quadrum)
          report_mismatch("quadrum_number", 64'(want.quadrum), 64'(got.quadrum));
        if (got.hour !== want.hour)
          report_mismatch("hour_of_day", 64'(want.hour), 64'(got.hour));
        if (got.minute !== want.minute)
          report_mismatch("minute_of_hour", 64'(want.minute), 64'(got.minute));
      end
    end
  end

  task automatic test_reset_defaults();
    send_word(OP_UNUSED, MAX_TICK);
    send_word(OP_ADVANCE, '0);
    send_word(OP_ADVANCE, '0);
    send_word(OP_LOAD, MAX_TICK);
    send_word(OP_ADVANCE, '0);
    send_word(OP_CLEAR, MAX_TICK);
  endtask

  task automatic test_register_extremes();
    set_calendar('1, '1, '1, '1);
    send_word(OP_LOAD, MAX_TICK);
    send_word(OP_LOAD, 31'h2AAA_AAAA);
    send_word(OP_LOAD, 31'h5555_5555);
    send_word(OP_ADVANCE, '0);
    send_word(OP_UNUSED, 31'h0123_4567);
    send_word(OP_CLEAR, 31'h7654_3210);
    send_word(OP_LOAD, 31'd65534);
  endtask

  task automatic test_calendar_boundaries();
    set_calendar(16'd100, 16'd7, 16'd12, 16'd5);
    send_word(OP_LOAD, 31'd99);
    send_word(OP_LOAD, 31'd100);
    send_word(OP_LOAD, 31'd1199);
    send_word(OP_ADVANCE, '0);
    send_word(OP_LOAD, 31'd6);
    send_word(OP_LOAD, 31'd513);
    set_calendar('0, 16'd3, '0, '1);
    send_word(OP_LOAD, 31'd5);
    send_word(OP_ADVANCE, '0);
    set_calendar(16'd10, '1, 16'd1, '0);
    send_word(OP_LOAD, 31'd9);
    send_word(OP_LOAD, 31'd70009);
  endtask

  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (10) send_word(OP_ADVANCE, TICK_W'($urandom()));
  endtask

  task automatic test_random_traffic(int count);
    int sent;
    int phase_len;
    int roll;
    sent = 0;
    while (sent < count) begin
      set_calendar(random_cal_value(), random_cal_value(), random_cal_value(),
                   random_cal_value());
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(60, 200);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 55)      send_word(OP_ADVANCE, TICK_W'($urandom()));
        else if (roll < 70) send_word(OP_LOAD, near_boundary());
        else if (roll < 82) send_word(OP_LOAD, TICK_W'($urandom()));
        else if (roll < 88) send_word(OP_LOAD, MAX_TICK - TICK_W'($urandom_range(0, 8)));
        else if (roll < 94) send_word(OP_CLEAR, TICK_W'($urandom()));
        else                send_word(OP_UNUSED, TICK_W'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    opcode       = OP_ADVANCE;
    load_value   = '0;
    out_ready    = 1'b0;
    tick_now     = '0;
    cal_reg      = '{'0, '0, '0, '0};
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_calendar_boundaries();
    test_output_stall();
    test_random_traffic(RANDOM_WORDS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_configurable_calendar_clock: clean");
    else
      $display("tb_configurable_calendar_clock: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/calclk_pkg.sv
rtl/calclk_div.sv
rtl/configurable_calendar_clock.sv
rtl/calclk_chk.sv
tb/sv/tb_configurable_calendar_clock.sv
